// ----- rtl/pbd_pkg.sv -----
// Package for the packed raw Bayer demosaic block.
// Holds the payload structs, sizes and register codes shared by all rtl/ files.
// No dependencies.
`default_nettype none

package pbd_pkg;

    // Line store depth and the widths that follow from it.
    localparam int MAX_PAIRS_PER_ROW = 2048;
    localparam int COL_W             = $clog2(MAX_PAIRS_PER_ROW);
    localparam int WIDTH_W           = COL_W + 1;

    // Configuration register sizes.
    localparam int CFG_W             = 12;
    localparam int CMP_W             = (CFG_W > WIDTH_W) ? CFG_W : WIDTH_W;
    localparam logic [CFG_W-1:0] CFG_PAIRS_RESET = 12'd2048;

    // APB port geometry: one 32-bit register at byte address zero.
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam logic REG_PAIRS_PER_ROW = 1'b0;

    // Nibble mask for the right sample's top bits.
    localparam logic [7:0] RIGHT_NIBBLE_MASK = 8'h0F;

    // Field widths.
    localparam int PIX_W             = 8;
    localparam int OUT_COL_W         = 11;

    typedef struct packed {
        logic [7:0] packed_byte_first;
        logic [7:0] packed_byte_middle;
        logic [7:0] packed_byte_last;
        logic       frame_start;
    } t_pbd_in;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green_upper;
        logic [PIX_W-1:0]     green_lower;
        logic [PIX_W-1:0]     blue;
        logic [OUT_COL_W-1:0] pair_column;
    } t_pbd_out;

    // Raster position of the pair being accepted.
    typedef struct packed {
        logic             odd;
        logic [COL_W-1:0] col;
    } t_pbd_slot;

endpackage

`default_nettype wire

// ----- rtl/pbd_line_store.sv -----
// Single-port line store holding the red/green pairs of the last even row.
// Depends on pbd_pkg for its depth and address width.
`default_nettype none

module pbd_line_store
    import pbd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [COL_W-1:0] i_addr,
    input  wire logic [15:0]      i_wdata,
    output logic      [15:0]      o_rdata
);

    logic [15:0] r_mem [MAX_PAIRS_PER_ROW];
    logic [15:0] r_rdata;

    // One access per cycle: a write on even rows, a registered read on odd rows.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/pbd_cfg_regs.sv -----
// APB register file holding the row width, plus its clamped effective value.
// Depends on pbd_pkg for register codes and widths.
`default_nettype none

module pbd_cfg_regs
    import pbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [WIDTH_W-1:0]    o_row_pairs
);

    logic [CFG_W-1:0] r_pairs;
    logic [CFG_W-1:0] n_pairs;
    logic             hit;
    logic [CMP_W-1:0] pairs_ext;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_PAIRS_PER_ROW);

    // A write lands in the access cycle of the transfer.
    always_comb begin
        n_pairs = r_pairs;
        if (psel && penable && pwrite && hit) begin
            n_pairs = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= CFG_PAIRS_RESET;
        end else begin
            r_pairs <= n_pairs;
        end
    end

    // Read back the raw register value.
    assign prdata = hit ? APB_DATA_W'(r_pairs) : '0;

    // Zero acts as one pair; anything above the line store depth acts as the depth.
    assign pairs_ext = CMP_W'(r_pairs);
    always_comb begin
        priority if (pairs_ext == '0) begin
            o_row_pairs = WIDTH_W'(1);
        end else if (pairs_ext > CMP_W'(MAX_PAIRS_PER_ROW)) begin
            o_row_pairs = WIDTH_W'(MAX_PAIRS_PER_ROW);
        end else begin
            o_row_pairs = WIDTH_W'(pairs_ext);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pbd_raster_ctl.sv -----
// Column and row parity tracking for the incoming pair stream.
// Depends on pbd_pkg for the slot struct and counter widths.
`default_nettype none

module pbd_raster_ctl
    import pbd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_frame_start,
    input  wire logic [WIDTH_W-1:0] i_row_pairs,
    output t_pbd_slot               o_slot
);

    logic [COL_W-1:0]   r_col;
    logic               r_odd;
    logic [COL_W-1:0]   n_col;
    logic               n_odd;
    logic [COL_W-1:0]   col_start;
    logic               odd_start;
    logic [WIDTH_W-1:0] col_next;

    // Frame start restarts the raster; a column past a lowered width ends the row.
    always_comb begin
        col_start = i_frame_start ? '0   : r_col;
        odd_start = i_frame_start ? 1'b0 : r_odd;
        if ({1'b0, col_start} >= i_row_pairs) begin
            o_slot.col = '0;
            o_slot.odd = ~odd_start;
        end else begin
            o_slot.col = col_start;
            o_slot.odd = odd_start;
        end
    end

    // Advance one column per transfer and wrap at the end of the row.
    assign col_next = {1'b0, o_slot.col} + WIDTH_W'(1);
    always_comb begin
        n_col = r_col;
        n_odd = r_odd;
        if (i_accept) begin
            if (col_next >= i_row_pairs) begin
                n_col = '0;
                n_odd = ~o_slot.odd;
            end else begin
                n_col = col_next[COL_W-1:0];
                n_odd = o_slot.odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_odd <= 1'b0;
        end else begin
            r_col <= n_col;
            r_odd <= n_odd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/packed_raw_bayer_demosaic.sv -----
// Top level of the packed raw Bayer demosaic (nearest neighbor, RGGB).
// Depends on pbd_pkg, pbd_cfg_regs, pbd_raster_ctl and pbd_line_store.
//
//   Channel  Direction  Handshake                   Payload
//   in       input      i_in_valid / o_in_ready     i_in_data  (t_pbd_in)
//   out      output     o_out_valid / i_out_ready   o_out_data (t_pbd_out)
//   cfg      input      APB psel/penable, pready=1  pairs_per_row at byte 0
//
// One pair is taken per clock while input ready is high. An odd-row pair passes
// through stage one, alongside the registered line store read, and then the
// output register. Even-row pairs only write the line store and give no result.
// Reset clears the counters and the pipeline valids and sets the width register
// to 2048; the line store is not cleared. A stalled output holds the pipeline,
// and input ready drops only while a result waits in a full output register.
`default_nettype none

module packed_raw_bayer_demosaic
    import pbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_pbd_in               i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_pbd_out                   o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic               accept;
    logic [WIDTH_W-1:0] row_pairs;
    t_pbd_slot          slot;
    logic [PIX_W-1:0]   left_pix;
    logic [PIX_W-1:0]   right_pix;
    logic [15:0]        store_rdata;
    logic               out_free;

    // Stage one: pair captured alongside the line store read.
    logic               r_s1_valid;
    logic               r_s1_odd;
    logic [PIX_W-1:0]   r_s1_left;
    logic [PIX_W-1:0]   r_s1_right;
    logic [COL_W-1:0]   r_s1_col;

    // Output register.
    logic               r_out_valid;
    t_pbd_out           r_out;
    logic               n_out_valid;

    pbd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_row_pairs (row_pairs)
    );

    pbd_raster_ctl u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_in_data.frame_start),
        .i_row_pairs   (row_pairs),
        .o_slot        (slot)
    );

    // Unpack the two samples, keeping the top eight bits of each.
    assign left_pix  = i_in_data.packed_byte_first;
    assign right_pix = {i_in_data.packed_byte_middle[3:0] & RIGHT_NIBBLE_MASK[3:0],
                        i_in_data.packed_byte_last[7:4]};

    pbd_line_store u_store (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (~slot.odd),
        .i_addr  (slot.col),
        .i_wdata ({left_pix, right_pix}),
        .o_rdata (store_rdata)
    );

    // Stage one drains unless it holds a result and the output register is blocked.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || !r_s1_odd || out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_odd   <= slot.odd;
            r_s1_left  <= left_pix;
            r_s1_right <= right_pix;
            r_s1_col   <= slot.col;
        end
    end

    // Output register: joins the stored upper pair with the current lower pair.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_s1_valid && r_s1_odd && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_odd && out_free) begin
            r_out.red         <= store_rdata[15:8];
            r_out.green_upper <= store_rdata[7:0];
            r_out.green_lower <= r_s1_left;
            r_out.blue        <= r_s1_right;
            r_out.pair_column <= OUT_COL_W'(r_s1_col);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A result only appears after an odd-row pair sat in stage one.
    a_out_from_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_odd))
        else $error("result raised without an odd-row pair in stage one");

    // Input backpressure only comes from a blocked output register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready && r_s1_valid && r_s1_odd))
        else $error("input stalled without a blocked result");

    // A frame start pair is column zero of an even row.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.frame_start) |-> (slot.col == '0 && !slot.odd))
        else $error("frame start did not restart the raster");

    // Every transferred pair addresses a column inside the current row width.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ({1'b0, slot.col} < row_pairs))
        else $error("column outside the row width");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for packed_raw_bayer_demosaic: sends packed Bayer pairs and APB width writes,
// keeps its own copy of the upper-row store and checks every 2x2 block that comes out.
// Depends on pbd_pkg and the block's sources under rtl/.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbd_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PAIRS    = 380;
    localparam int MAX_REPORTS     = 100;
    localparam logic [APB_ADDR_W-1:0] PAIRS_ADDR   = APB_ADDR_W'(4 * REG_PAIRS_PER_ROW);
    localparam logic [CFG_W-1:0]      CFG_TOO_WIDE = '1;

    // Block ports.
    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_pbd_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_pbd_out              out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted state of the raster counters, the width register and the line store.
    logic [CFG_W-1:0] row_pairs_cfg = CFG_PAIRS_RESET;
    int unsigned      col_count     = 0;
    bit               odd_row       = 1'b0;
    logic [15:0]      upper_rows [MAX_PAIRS_PER_ROW];
    bit               upper_seen [MAX_PAIRS_PER_ROW];
    t_pbd_out         pending_blocks [$];

    int unsigned error_count = 0;
    int unsigned pairs_sent  = 0;
    int unsigned idle_cycles = 0;
    int unsigned sink_hold   = 0;
    bit          gaps_on     = 1'b1;
    bit          src_busy    = 1'b0;

    packed_raw_bayer_demosaic DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Effective row width: zero acts as one, anything past the store depth is clamped.
    function automatic int unsigned row_width();
        if (row_pairs_cfg == '0) return 1;
        if (row_pairs_cfg > MAX_PAIRS_PER_ROW) return MAX_PAIRS_PER_ROW;
        return row_pairs_cfg;
    endfunction

    // Row parity and column at which a pair lands, before the counters advance.
    function automatic void land_slot(input t_pbd_in p, output bit odd, output int unsigned col);
        odd = odd_row;
        col = col_count;
        if (p.frame_start) begin
            odd = 1'b0;
            col = 0;
        end
        if (col >= row_width()) begin
            col = 0;
            odd = !odd;
        end
    endfunction

    // Even-row pairs fill the store; odd-row pairs join it into one RGB block.
    function automatic void predict_block(input t_pbd_in p);
        bit          odd;
        int unsigned col;
        logic [7:0]  left;
        logic [7:0]  right;
        t_pbd_out    blk;
        land_slot(p, odd, col);
        left  = p.packed_byte_first;
        right = {p.packed_byte_middle[3:0], p.packed_byte_last[7:4]};
        if (!odd) begin
            upper_rows[col] = {left, right};
            upper_seen[col] = 1'b1;
        end else begin
            blk.red         = upper_rows[col][15:8];
            blk.green_upper = upper_rows[col][7:0];
            blk.green_lower = left;
            blk.blue        = right;
            blk.pair_column = col[OUT_COL_W-1:0];
            pending_blocks.push_back(blk);
        end
        col++;
        if (col >= row_width()) begin
            col = 0;
            odd = !odd;
        end
        col_count = col;
        odd_row   = odd;
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic t_pbd_in random_pair(input bit first_of_frame);
        t_pbd_in p;
        p.packed_byte_first  = 8'($urandom_range(255));
        p.packed_byte_middle = 8'($urandom_range(255));
        p.packed_byte_last   = 8'($urandom_range(255));
        p.frame_start        = first_of_frame;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Offer one pair until it is taken, then update the prediction and maybe idle.
    task automatic push_pair(input t_pbd_in p);
        bit          odd;
        int unsigned col;
        int unsigned gap;
        land_slot(p, odd, col);
        // An odd-row pair must find its column written on an earlier even row.
        if (odd && !upper_seen[col]) p.frame_start = 1'b1;
        src_busy = 1'b1;
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (!in_ready);
        predict_block(p);
        pairs_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            src_busy = 1'b0;
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop the source and wait until every predicted block has been seen.
    task automatic wait_drained();
        if (src_busy) begin
            src_busy = 1'b0;
            in_valid <= 1'b0;
        end
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the width register followed by a read back.
    task automatic write_row_pairs(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAIRS_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        row_pairs_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[CFG_W-1:0] !== value)
            report_mismatch("pairs_per_row read back", prdata, value);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : sink_ready
        int unsigned gap;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                out_ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end else begin
                gap = pick_gap();
                if (gap > 0 && $urandom_range(99) < 30) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Compare every output transfer with the oldest predicted block.
    always @(posedge i_clk) begin : block_checker
        t_pbd_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("unexpected block at pair_column", out_data.pair_column, 0);
            end else begin
                want = pending_blocks.pop_front();
                if (out_data.red !== want.red)
                    report_mismatch("red", out_data.red, want.red);
                if (out_data.green_upper !== want.green_upper)
                    report_mismatch("green_upper", out_data.green_upper, want.green_upper);
                if (out_data.green_lower !== want.green_lower)
                    report_mismatch("green_lower", out_data.green_lower, want.green_lower);
                if (out_data.blue !== want.blue)
                    report_mismatch("blue", out_data.blue, want.blue);
                if (out_data.pair_column !== want.pair_column)
                    report_mismatch("pair_column", out_data.pair_column, want.pair_column);
            end
        end
    end

    // End the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin : stall_watch
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset width: a stretch of one even row is stored and gives no blocks.
    task automatic test_reset_width();
        push_pair(random_pair(1'b1));
        repeat (39) push_pair(random_pair(1'b0));
        wait_drained();
        // A width past the store depth is clamped, so the even row carries on.
        write_row_pairs(CFG_TOO_WIDE);
        repeat (6) push_pair(random_pair(1'b0));
        wait_drained();
        // Lowering the width mid-row ends the row, and the odd row reads the stored pairs.
        write_row_pairs(12'd8);
        repeat (8) push_pair(random_pair(1'b0));
        wait_drained();
    endtask

    // Zero width acts as one pair per row; a width of one then gives the same rows.
    task automatic test_extreme_pairs();
        write_row_pairs('0);
        push_pair(t_pbd_in'{8'hFF, 8'h0F, 8'hF0, 1'b0});
        push_pair(t_pbd_in'{8'h00, 8'hF0, 8'h0F, 1'b0});
        push_pair(t_pbd_in'{8'h00, 8'h00, 8'h00, 1'b0});
        push_pair(t_pbd_in'{8'hFF, 8'hFF, 8'hFF, 1'b0});
        push_pair(t_pbd_in'{8'h00, 8'hFF, 8'h0F, 1'b0});
        push_pair(t_pbd_in'{8'hFF, 8'h0F, 8'hF0, 1'b0});
        push_pair(t_pbd_in'{8'h00, 8'hF0, 8'h0F, 1'b1});
        push_pair(t_pbd_in'{8'h80, 8'h08, 8'h80, 1'b0});
        wait_drained();
        write_row_pairs(12'd1);
        repeat (4) push_pair(random_pair(1'b0));
        wait_drained();
    endtask

    // Frame start in the middle of an even row and of an odd row.
    task automatic test_frame_restart();
        write_row_pairs(12'd4);
        push_pair(random_pair(1'b1));
        push_pair(random_pair(1'b0));
        push_pair(random_pair(1'b1));
        repeat (3) push_pair(random_pair(1'b0));
        repeat (2) push_pair(random_pair(1'b0));
        push_pair(random_pair(1'b1));
        repeat (3) push_pair(random_pair(1'b0));
        repeat (4) push_pair(random_pair(1'b0));
        wait_drained();
    endtask

    // Long output hold-off while the source keeps offering, then a full source pause.
    task automatic test_backpressure();
        write_row_pairs(12'd6);
        gaps_on = 1'b0;
        sink_hold = HOLD_OFF_CYCLES;
        push_pair(random_pair(1'b1));
        repeat (47) push_pair(random_pair(1'b0));
        wait_drained();
        gaps_on = 1'b1;
        repeat (24) push_pair(random_pair(1'b0));
        wait_drained();
    endtask

    // Random widths and frames; most phases start a fresh frame, some continue mid-row.
    task automatic test_random_stream();
        int unsigned      start_count;
        int unsigned      n;
        int unsigned      r;
        logic [CFG_W-1:0] w;
        start_count = pairs_sent;
        while (pairs_sent - start_count < RANDOM_PAIRS) begin
            r = $urandom_range(99);
            if (r < 5)       w = '0;
            else if (r < 10) w = CFG_W'($urandom_range(4095, MAX_PAIRS_PER_ROW + 1));
            else if (r < 15) w = 12'd1;
            else             w = CFG_W'($urandom_range(24, 2));
            write_row_pairs(w);
            gaps_on = ($urandom_range(3) != 0);
            n = $urandom_range(70, 30);
            for (int k = 0; k < n; k++)
                push_pair(random_pair((k == 0 && $urandom_range(4) != 0) ||
                                      $urandom_range(49) == 0));
            wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial begin : run_tests
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_width();
        test_extreme_pairs();
        test_frame_restart();
        test_backpressure();
        test_random_stream();
        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
